>>> rtl/tsi_pkg.sv
// shared constants, codes and types of the turtle symbol interpreter
`default_nettype none

package tsi_pkg;

  // branch stack depth and angle resolution
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned ANGLE_BITS  = 16;
  localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);
  localparam int unsigned LEVEL_W     = $clog2(STACK_DEPTH + 1);

  localparam int unsigned COORD_W = 24;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned ENTRY_W = 2 * COORD_W + ANGLE_BITS;

  // serial multiplier operand width
  localparam int unsigned MUL_W = 32;

  // configuration register indexes
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_ORIGIN_X   = 3'd0;
  localparam reg_idx_t REG_ORIGIN_Y   = 3'd1;
  localparam reg_idx_t REG_INIT_HEAD  = 3'd2;
  localparam reg_idx_t REG_TURN_STEP  = 3'd3;
  localparam reg_idx_t REG_STEP_LEN   = 3'd4;

  // symbol codes
  localparam logic [7:0] SYM_FWD   = 8'h46;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_PUSH  = 8'h5B;
  localparam logic [7:0] SYM_POP   = 8'h5D;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_UNDERFLOW = 2'd1,
    FAULT_OVERFLOW  = 2'd2,
    FAULT_SATURATED = 2'd3
  } fault_e;

  // sine polynomial coefficients, q30
  localparam logic [MUL_W-1:0] K1 = 32'd1686629713;
  localparam logic [MUL_W-1:0] K3 = 32'd693598668;
  localparam logic [MUL_W-1:0] K5 = 32'd85569306;
  localparam logic [MUL_W-1:0] K7 = 32'd5026996;
  localparam logic [MUL_W-1:0] K9 = 32'd172272;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] dir;
    logic [COUNT_W-1:0]    count;
    logic [LEN_W-1:0]      len;
  } move_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
  } move_res_t;

endpackage

`default_nettype wire

>>> rtl/tsi_serial_mul.sv
// bit-serial unsigned shift-add multiplier
`default_nettype none

module tsi_serial_mul import tsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MUL_W-1:0]     a_i,
  input  logic [MUL_W-1:0]     b_i,
  output logic                 done_o,
  output logic [2*MUL_W-1:0]   p_o
);

  localparam int unsigned CNT_W = $clog2(MUL_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MUL_W-1:0] a_q, a_d, hi_q, hi_d, lo_q, lo_d;
  logic [MUL_W:0]   sum;

  // one multiplier bit per cycle
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      a_d    = a_i;
      hi_d   = '0;
      lo_d   = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum[MUL_W:1];
      lo_d  = {sum[0], lo_q[MUL_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(MUL_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign p_o    = {hi_q, lo_q};

endmodule

`default_nettype wire

>>> rtl/tsi_move.sv
// move sequencer: distance, sine and cosine polynomial and scaling on one serial multiplier
`default_nettype none

module tsi_move import tsi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  move_req_t req_i,
  output logic      done_o,
  output move_res_t res_o
);

  typedef enum logic [7:0] {
    STEP_DIST  = 8'b0000_0001,
    STEP_SQ    = 8'b0000_0010,
    STEP_K9    = 8'b0000_0100,
    STEP_K5    = 8'b0000_1000,
    STEP_K3    = 8'b0001_0000,
    STEP_K1    = 8'b0010_0000,
    STEP_SIN   = 8'b0100_0000,
    STEP_SCALE = 8'b1000_0000
  } step_e;

  logic               busy_q, busy_d;
  logic               issue_q, issue_d;
  logic               done_q, done_d;
  logic               angle_q, angle_d;
  step_e              step_q, step_d;
  move_req_t          req_q, req_d;
  logic [MUL_W-1:0]   dist_q, dist_d, x2_q, x2_d, t_q, t_d;
  logic [COORD_W-1:0] dx_q, dx_d, dy_q, dy_d;

  logic [MUL_W-1:0]   ph, fold, x, mul_a, mul_b, p_mid;
  logic               neg, mul_done;
  logic [2*MUL_W-1:0] p;
  logic [COORD_W-1:0] rnd, disp;

  // angle 0 is the cosine (phase plus a quarter turn), angle 1 the sine
  always_comb begin
    ph   = {req_q.dir, {(MUL_W - ANGLE_BITS){1'b0}}}
         + (angle_q ? 32'h0000_0000 : 32'h4000_0000);
    neg  = ph[MUL_W-1];
    fold = {1'b0, ph[MUL_W-2:0]};
    x    = (fold > 32'h4000_0000) ? (32'h8000_0000 - fold) : fold;
  end

  always_comb begin
    unique case (step_q)
      STEP_DIST: begin
        mul_a = MUL_W'(req_q.count);
        mul_b = MUL_W'(req_q.len);
      end
      STEP_SQ: begin
        mul_a = x;
        mul_b = x;
      end
      STEP_K9: begin
        mul_a = x2_q;
        mul_b = K9;
      end
      STEP_SIN: begin
        mul_a = x;
        mul_b = t_q;
      end
      STEP_SCALE: begin
        mul_a = dist_q;
        mul_b = t_q;
      end
      default: begin
        mul_a = x2_q;
        mul_b = t_q;
      end
    endcase
  end

  tsi_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (issue_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (p)
  );

  // product shifted down by 30, and the rounded signed displacement
  assign p_mid = p[61:30];
  assign rnd   = p[53:30] + COORD_W'(p[29]);
  assign disp  = neg ? (~rnd + 1'b1) : rnd;

  always_comb begin
    busy_d  = busy_q;
    issue_d = 1'b0;
    done_d  = 1'b0;
    angle_d = angle_q;
    step_d  = step_q;
    req_d   = req_q;
    dist_d  = dist_q;
    x2_d    = x2_q;
    t_d     = t_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    if (start_i) begin
      req_d   = req_i;
      busy_d  = 1'b1;
      issue_d = 1'b1;
      angle_d = 1'b0;
      step_d  = STEP_DIST;
    end else if (busy_q && mul_done) begin
      issue_d = 1'b1;
      unique case (step_q)
        STEP_DIST: begin
          dist_d = p[MUL_W-1:0];
          step_d = STEP_SQ;
        end
        STEP_SQ: begin
          x2_d   = p_mid;
          step_d = STEP_K9;
        end
        STEP_K9: begin
          t_d    = K7 - p_mid;
          step_d = STEP_K5;
        end
        STEP_K5: begin
          t_d    = K5 - p_mid;
          step_d = STEP_K3;
        end
        STEP_K3: begin
          t_d    = K3 - p_mid;
          step_d = STEP_K1;
        end
        STEP_K1: begin
          t_d    = K1 - p_mid;
          step_d = STEP_SIN;
        end
        STEP_SIN: begin
          t_d    = p_mid;
          step_d = STEP_SCALE;
        end
        STEP_SCALE: begin
          step_d = STEP_SQ;
          if (!angle_q) begin
            dx_d    = disp;
            angle_d = 1'b1;
          end else begin
            dy_d    = disp;
            issue_d = 1'b0;
            busy_d  = 1'b0;
            done_d  = 1'b1;
          end
        end
        default: step_d = STEP_DIST;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      issue_q <= 1'b0;
      done_q  <= 1'b0;
      angle_q <= 1'b0;
      step_q  <= STEP_DIST;
    end else begin
      busy_q  <= busy_d;
      issue_q <= issue_d;
      done_q  <= done_d;
      angle_q <= angle_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    dist_q <= dist_d;
    x2_q   <= x2_d;
    t_q    <= t_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
  end

  assign done_o = done_q;
  assign res_o  = '{dx: dx_q, dy: dy_q};

endmodule

`default_nettype wire

>>> rtl/tsi_stack_ram.sv
// branch stack storage with registered read
`default_nettype none

module tsi_stack_ram import tsi_pkg::*; (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [STACK_AW-1:0] waddr_i,
  input  logic [ENTRY_W-1:0]  wdata_i,
  input  logic                re_i,
  input  logic [STACK_AW-1:0] raddr_i,
  output logic [ENTRY_W-1:0]  rdata_o
);

  logic [ENTRY_W-1:0] mem_q [STACK_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/turtle_symbol_interpreter_unit.sv
// top level of the turtle symbol interpreter: symbol sequencer, output staging and config
`default_nettype none

// turtle symbol interpreter. symbols arrive one per input transaction and are handled one at a
// time; a '+'/'-' run followed by an 'F' run forms a group, and the symbol that closes a group
// (or a final symbol) makes the block emit the new vertex. a symbol that closes a group waits
// on the bit-serial multiplier that is shared by the fifteen products of one move (distance,
// the two degree-nine sine polynomials and the two scalings).
// a first symbol restarts the turtle at the origin and emits that point before the symbol is
// handled.
// '[' and ']' push and pop position and heading on a 64-entry stack held in a ram; entries
// read back are only those pushed since the restart, so there is no clearing pass after
// reset. a push on a full stack or a pop on an empty one emits the current point with a fault
// code; a group vertex whose forward count saturated carries its own fault code. a result
// waits in an output register, so the next symbol is taken while it is still pending; a
// stalled receiver holds the sequencer once both result registers are full. the user must write
// configuration through the plain write port only while the block is idle; it is not enforced.
module turtle_symbol_interpreter_unit import tsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // symbol stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // symbol
  input  logic                 s_axis_tuser,   // first_symbol
  input  logic                 s_axis_tlast,   // final_symbol
  // vertex stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*COORD_W-1:0] m_axis_tdata,   // point_x [23:0], point_y [47:24]
  output logic [1:0]           m_axis_tuser,   // fault
  output logic                 m_axis_tlast    // last_point
);

  typedef enum logic [9:0] {
    ST_IDLE       = 10'b00_0000_0001,
    ST_SYM        = 10'b00_0000_0010,
    ST_TURN       = 10'b00_0000_0100,
    ST_BRACKET    = 10'b00_0000_1000,
    ST_POP        = 10'b00_0001_0000,
    ST_FIN        = 10'b00_0010_0000,
    ST_FLUSH      = 10'b00_0100_0000,
    ST_FLUSH_WAIT = 10'b00_1000_0000,
    ST_NEWRES     = 10'b01_0000_0000,
    ST_DONE       = 10'b10_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TURN = 2'd1,
    PH_FWD  = 2'd2
  } phase_e;

  // configuration registers
  logic [COORD_W-1:0]    origin_x_q, origin_y_q;
  logic [15:0]           init_head_q, turn_step_q;
  logic [LEN_W-1:0]      step_len_q;

  // turtle state
  state_e                state_q, state_d, ret_q, ret_d;
  phase_e                phase_q, phase_d;
  logic [COORD_W-1:0]    pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [ANGLE_BITS-1:0] heading_q, heading_d, turn_q, turn_d, dir;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [LEVEL_W-1:0]    level_q, level_d, level_m1;
  fault_e                res_fault_q, res_fault_d;

  // latched symbol
  logic [7:0]            sym_q, sym_d;
  logic                  fin_q, fin_d;

  // pending result and output register
  logic                  pend_v_q, pend_v_d;
  logic [COORD_W-1:0]    pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  fault_e                pend_fault_q, pend_fault_d;
  logic                  out_v_q, out_v_d, out_last_q, out_last_d;
  logic [COORD_W-1:0]    out_x_q, out_x_d, out_y_q, out_y_d;
  fault_e                out_fault_q, out_fault_d;
  logic                  out_free, out_load, out_last_new;

  // stack and move unit
  logic                  ram_we, ram_re;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic                  move_start, move_done;
  move_req_t             move_req;
  move_res_t             move_res;

  logic                  is_turn, is_plus;

  assign dir      = heading_q + turn_q;
  assign out_free = !out_v_q || m_axis_tready;
  assign level_m1 = level_q - 1'b1;
  assign is_plus  = (sym_q == SYM_PLUS);
  assign is_turn  = is_plus || (sym_q == SYM_MINUS);
  assign move_req = '{dir: dir, count: count_q, len: step_len_q};

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= 24'd51200;
      origin_y_q  <= 24'd51200;
      init_head_q <= 16'd16384;
      turn_step_q <= 16'd4551;
      step_len_q  <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ORIGIN_X:  origin_x_q  <= cfg_wdata_i;
        REG_ORIGIN_Y:  origin_y_q  <= cfg_wdata_i;
        REG_INIT_HEAD: init_head_q <= cfg_wdata_i[15:0];
        REG_TURN_STEP: turn_step_q <= cfg_wdata_i[15:0];
        REG_STEP_LEN:  step_len_q  <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // symbol sequencer
  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    phase_d      = phase_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    heading_d    = heading_q;
    turn_d       = turn_q;
    count_d      = count_q;
    level_d      = level_q;
    res_fault_d  = res_fault_q;
    sym_d        = sym_q;
    fin_d        = fin_q;
    pend_v_d     = pend_v_q;
    pend_x_d     = pend_x_q;
    pend_y_d     = pend_y_q;
    pend_fault_d = pend_fault_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    move_start   = 1'b0;
    out_load     = 1'b0;
    out_last_new = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          sym_d = s_axis_tdata;
          fin_d = s_axis_tlast;
          if (s_axis_tuser) begin
            // restart from the configured origin and emit it first
            pos_x_d     = origin_x_q;
            pos_y_d     = origin_y_q;
            heading_d   = ANGLE_BITS'(init_head_q);
            turn_d      = '0;
            count_d     = '0;
            phase_d     = PH_IDLE;
            level_d     = '0;
            res_fault_d = FAULT_NONE;
            ret_d       = ST_SYM;
            state_d     = ST_NEWRES;
          end else begin
            state_d = ST_SYM;
          end
        end
      end
      ST_SYM: begin
        if (is_turn) begin
          if (phase_q == PH_FWD) begin
            ret_d   = ST_TURN;
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_TURN;
          end
        end else if (sym_q == SYM_FWD) begin
          if (count_q != '1) begin
            count_d = count_q + 1'b1;
          end
          phase_d = PH_FWD;
          state_d = ST_FIN;
        end else if (phase_q != PH_IDLE) begin
          ret_d   = ST_BRACKET;
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_BRACKET;
        end
      end
      ST_TURN: begin
        turn_d  = is_plus ? (turn_q + ANGLE_BITS'(turn_step_q))
                          : (turn_q - ANGLE_BITS'(turn_step_q));
        phase_d = PH_TURN;
        state_d = ST_FIN;
      end
      ST_BRACKET: begin
        state_d = ST_FIN;
        if (sym_q == SYM_PUSH) begin
          if (level_q == LEVEL_W'(STACK_DEPTH)) begin
            res_fault_d = FAULT_OVERFLOW;
            ret_d       = ST_FIN;
            state_d     = ST_NEWRES;
          end else begin
            ram_we  = 1'b1;
            level_d = level_q + 1'b1;
          end
        end else if (sym_q == SYM_POP) begin
          if (level_q == '0) begin
            res_fault_d = FAULT_UNDERFLOW;
            ret_d       = ST_FIN;
            state_d     = ST_NEWRES;
          end else begin
            ram_re  = 1'b1;
            level_d = level_m1;
            state_d = ST_POP;
          end
        end
      end
      ST_POP: begin
        pos_x_d   = ram_rdata[ENTRY_W-1 -: COORD_W];
        pos_y_d   = ram_rdata[ANGLE_BITS +: COORD_W];
        heading_d = ram_rdata[ANGLE_BITS-1:0];
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        // a final symbol flushes any open group
        if (fin_q && (phase_q != PH_IDLE)) begin
          ret_d   = ST_DONE;
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FLUSH: begin
        move_start = 1'b1;
        state_d    = ST_FLUSH_WAIT;
      end
      ST_FLUSH_WAIT: begin
        if (move_done) begin
          pos_x_d     = pos_x_q + move_res.dx;
          pos_y_d     = pos_y_q + move_res.dy;
          heading_d   = dir;
          res_fault_d = (count_q == '1) ? FAULT_SATURATED : FAULT_NONE;
          turn_d      = '0;
          count_d     = '0;
          phase_d     = PH_IDLE;
          state_d     = ST_NEWRES;
        end
      end
      ST_NEWRES: begin
        // the held result moves on only once it is known not to be the last one
        if (!pend_v_q || out_free) begin
          out_load     = pend_v_q;
          pend_v_d     = 1'b1;
          pend_x_d     = pos_x_q;
          pend_y_d     = pos_y_q;
          pend_fault_d = res_fault_q;
          state_d      = ret_q;
        end
      end
      ST_DONE: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_last_new = fin_q;
          pend_v_d     = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_v_d     = out_v_q && !m_axis_tready;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_fault_d = out_fault_q;
    out_last_d  = out_last_q;
    if (out_load) begin
      out_v_d     = 1'b1;
      out_x_d     = pend_x_q;
      out_y_d     = pend_y_q;
      out_fault_d = pend_fault_q;
      out_last_d  = out_last_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      phase_q     <= PH_IDLE;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      turn_q      <= '0;
      count_q     <= '0;
      level_q     <= '0;
      res_fault_q <= FAULT_NONE;
      pend_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      phase_q     <= phase_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      heading_q   <= heading_d;
      turn_q      <= turn_d;
      count_q     <= count_d;
      level_q     <= level_d;
      res_fault_q <= res_fault_d;
      pend_v_q    <= pend_v_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q        <= sym_d;
    fin_q        <= fin_d;
    pend_x_q     <= pend_x_d;
    pend_y_q     <= pend_y_d;
    pend_fault_q <= pend_fault_d;
    out_x_q      <= out_x_d;
    out_y_q      <= out_y_d;
    out_fault_q  <= out_fault_d;
    out_last_q   <= out_last_d;
  end

  tsi_stack_ram u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (level_q[STACK_AW-1:0]),
    .wdata_i ({pos_x_q, pos_y_q, heading_q}),
    .re_i    (ram_re),
    .raddr_i (level_m1[STACK_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  tsi_move u_move (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (move_start),
    .req_i   (move_req),
    .done_o  (move_done),
    .res_o   (move_res)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tuser  = out_fault_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LEVEL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !pend_v_q)
    else $error("new symbol taken with a result still held");
  a_move_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move_done |-> (state_q == ST_FLUSH_WAIT))
    else $error("move finished outside a flush");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (out_free && pend_v_q))
    else $error("output register overwritten");
`endif

endmodule

`default_nettype wire
